FILE: rtl/core/aes_xcbc_mac_core_assert.svh
// Assertion macros used by the back-end module.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef AES_XCBC_MAC_CORE_ASSERT_SVH
`define AES_XCBC_MAC_CORE_ASSERT_SVH

// Same-cycle implication.
`define AXM_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define AXM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/axm_pkg.sv
package axm_pkg;

    // Queued message block, already padded.
    typedef struct packed {
        logic [127:0] blk;
        logic         last;
        logic         pad;
    } item_t;

    // Request into the AES unit.
    typedef struct packed {
        logic         start;
        logic [127:0] key;
        logic [127:0] blk;
    } eng_req_t;

    // Status from the AES unit.
    typedef struct packed {
        logic         busy;
        logic         done;
        logic [127:0] result;
    } eng_rsp_t;

    localparam logic [4:0]  FULL_BYTES = 5'd16;
    localparam logic [7:0]  PAD_BYTE   = 8'h80;
    localparam logic [3:0]  LAST_ROUND = 4'd10;
    localparam logic [63:0] FILL_K1    = 64'h0101010101010101;
    localparam logic [63:0] FILL_K2    = 64'h0202020202020202;
    localparam logic [63:0] FILL_K3    = 64'h0303030303030303;

    localparam logic [2047:0] SBOX_TABLE = {
        128'h637c777bf26b6fc53001672bfed7ab76,
        128'hca82c97dfa5947f0add4a2af9ca472c0,
        128'hb7fd9326363ff7cc34a5e5f171d83115,
        128'h04c723c31896059a071280e2eb27b275,
        128'h09832c1a1b6e5aa0523bd6b329e32f84,
        128'h53d100ed20fcb15b6acbbe394a4c58cf,
        128'hd0efaafb434d338545f9027f503c9fa8,
        128'h51a3408f929d38f5bcb6da2110fff3d2,
        128'hcd0c13ec5f974417c4a77e3d645d1973,
        128'h60814fdc222a908846eeb814de5e0bdb,
        128'he0323a0a4906245cc2d3ac629195e479,
        128'he7c8376d8dd54ea96c56f4ea657aae08,
        128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
        128'h703eb5664803f60e613557b986c11d9e,
        128'he1f8981169d98e949b1e87e9ce5528df,
        128'h8ca1890dbfe6426841992d0fb054bb16
    };

    function automatic logic [7:0] sub_byte(input logic [7:0] x);
        return SBOX_TABLE[2047 - 8 * int'(x) -: 8];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] rnd);
        logic [7:0] r;
        case (rnd)
            4'd1:    r = 8'h01;
            4'd2:    r = 8'h02;
            4'd3:    r = 8'h04;
            4'd4:    r = 8'h08;
            4'd5:    r = 8'h10;
            4'd6:    r = 8'h20;
            4'd7:    r = 8'h40;
            4'd8:    r = 8'h80;
            4'd9:    r = 8'h1b;
            4'd10:   r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // One step of the AES-128 key schedule.
    function automatic logic [127:0] key_step(input logic [127:0] rk, input logic [7:0] rc);
        logic [31:0] tmp;
        logic [31:0] n0;
        logic [31:0] n1;
        logic [31:0] n2;
        logic [31:0] n3;
        tmp = {sub_byte(rk[23:16]) ^ rc, sub_byte(rk[15:8]), sub_byte(rk[7:0]),
               sub_byte(rk[31:24])};
        n0 = rk[127:96] ^ tmp;
        n1 = rk[95:64] ^ n0;
        n2 = rk[63:32] ^ n1;
        n3 = rk[31:0] ^ n2;
        return {n0, n1, n2, n3};
    endfunction

    // One AES round; the final round skips MixColumns.
    function automatic logic [127:0] aes_round(input logic [127:0] s,
                                               input logic [127:0] rk,
                                               input logic fin);
        logic [7:0]   b [16];
        logic [7:0]   t [16];
        logic [7:0]   o [16];
        logic [7:0]   all;
        logic [127:0] res;
        for (int i = 0; i < 16; i++) begin
            b[i] = s[127 - 8 * i -: 8];
        end
        for (int i = 0; i < 16; i++) begin
            t[i] = sub_byte(b[(i & 3) + 4 * (((i >> 2) + (i & 3)) & 3)]);
        end
        for (int c = 0; c < 4; c++) begin
            all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
            if (fin) begin
                o[4*c]   = t[4*c];
                o[4*c+1] = t[4*c+1];
                o[4*c+2] = t[4*c+2];
                o[4*c+3] = t[4*c+3];
            end
            else begin
                o[4*c]   = t[4*c]   ^ all ^ xtime(t[4*c]   ^ t[4*c+1]);
                o[4*c+1] = t[4*c+1] ^ all ^ xtime(t[4*c+1] ^ t[4*c+2]);
                o[4*c+2] = t[4*c+2] ^ all ^ xtime(t[4*c+2] ^ t[4*c+3]);
                o[4*c+3] = t[4*c+3] ^ all ^ xtime(t[4*c+3] ^ t[4*c]);
            end
        end
        for (int i = 0; i < 16; i++) begin
            res[127 - 8 * i -: 8] = o[i] ^ rk[127 - 8 * i -: 8];
        end
        return res;
    endfunction

endpackage

FILE: rtl/core/axm_front.sv
// Input side: pads short last blocks and queues all blocks for the back end.
module axm_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [63:0]      block_high,
    input  logic [63:0]      block_low,
    input  logic [4:0]       byte_count,
    input  logic             last,
    output logic             item_valid,
    output axm_pkg::item_t   item,
    input  logic             take
);

    axm_pkg::item_t in_item;
    axm_pkg::item_t q_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     cnt_reg;
    logic [1:0]     cnt_next;
    logic           do_push;
    logic           do_take;
    logic [127:0]   raw;
    logic           short_blk;

    // Padding of a short last block
    always_comb
    begin
        raw       = {block_high, block_low};
        short_blk = last && (byte_count < axm_pkg::FULL_BYTES);
        for (int i = 0; i < 16; i++) begin
            if (!short_blk || 5'(i) < byte_count) begin
                in_item.blk[127 - 8 * i -: 8] = raw[127 - 8 * i -: 8];
            end
            else if (5'(i) == byte_count) begin
                in_item.blk[127 - 8 * i -: 8] = axm_pkg::PAD_BYTE;
            end
            else begin
                in_item.blk[127 - 8 * i -: 8] = 8'h00;
            end
        end
        in_item.last = last;
        in_item.pad  = short_blk;
    end

    assign full       = (cnt_reg == 2'd2);
    assign do_push    = push && !full;
    assign item_valid = (cnt_reg != 2'd0);
    assign do_take    = take && item_valid;
    assign item       = q_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg + 2'(do_push) - 2'(do_take);
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (do_push) begin
            q_reg[wr_ptr_reg] <= in_item;
        end
    end

    // Queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else begin
            if (do_push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_take) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

FILE: rtl/core/axm_engine.sv
// Iterative AES-128: one round per cycle, round keys expanded on the fly.
module axm_engine (
    input  logic                clk,
    input  logic                rst_n,
    input  axm_pkg::eng_req_t   req,
    output axm_pkg::eng_rsp_t   rsp
);

    logic [127:0] st_reg;
    logic [127:0] rk_reg;
    logic [127:0] rk_next;
    logic [3:0]   rnd_reg;
    logic         busy_reg;
    logic         done_reg;

    assign rk_next = axm_pkg::key_step(rk_reg, axm_pkg::rcon(rnd_reg));

    // Datapath
    always_ff @(posedge clk)
    begin
        if (req.start) begin
            st_reg <= req.blk ^ req.key;
            rk_reg <= req.key;
        end
        else if (busy_reg) begin
            st_reg <= axm_pkg::aes_round(st_reg, rk_next, rnd_reg == axm_pkg::LAST_ROUND);
            rk_reg <= rk_next;
        end
    end

    // Round counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rnd_reg  <= 4'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (req.start) begin
            rnd_reg  <= 4'd1;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg) begin
            if (rnd_reg == axm_pkg::LAST_ROUND) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else begin
                rnd_reg <= rnd_reg + 4'd1;
            end
        end
        else begin
            done_reg <= 1'b0;
        end
    end

    assign rsp.busy   = busy_reg;
    assign rsp.done   = done_reg;
    assign rsp.result = st_reg;

endmodule

FILE: rtl/core/axm_back.sv
`include "aes_xcbc_mac_core_assert.svh"
// Back end: subkey derivation, CBC chaining and the tag queue.
module axm_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic                cfg_index,
    input  logic [63:0]         cfg_data,
    input  logic                item_valid,
    input  axm_pkg::item_t      item,
    output logic                take,
    output axm_pkg::eng_req_t   req,
    input  axm_pkg::eng_rsp_t   rsp,
    output logic                empty,
    input  logic                pop,
    output logic [63:0]         mac_high,
    output logic [63:0]         mac_low
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DERIVE = 2'd1;
    localparam logic [1:0] S_MAIN   = 2'd2;

    localparam logic [1:0] PH_K1 = 2'd1;
    localparam logic [1:0] PH_K2 = 2'd2;
    localparam logic [1:0] PH_K3 = 2'd3;

    logic [1:0]   state_reg;
    logic [1:0]   state_next;
    logic [1:0]   phase_reg;
    logic [1:0]   phase_next;
    logic [63:0]  key_high_reg;
    logic [63:0]  key_low_reg;
    logic         ready_reg;
    logic         ready_next;
    logic [127:0] chain_reg;
    logic [127:0] chain_next;
    logic [127:0] k1_reg;
    logic [127:0] k2_reg;
    logic [127:0] k3_reg;
    logic         cur_last_reg;
    logic         cur_last_next;
    logic         push;
    logic         room;
    logic         main_done;
    logic [127:0] chain_src;
    logic [127:0] q_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   out_cnt_reg;
    logic         do_pop;

    assign main_done = (state_reg == S_MAIN) && rsp.done;
    assign push      = main_done && cur_last_reg;
    assign room      = (out_cnt_reg == 2'd0) || ((out_cnt_reg == 2'd1) && !push);
    assign chain_src = main_done ? (cur_last_reg ? 128'd0 : rsp.result) : chain_reg;

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        ready_next    = ready_reg;
        cur_last_next = cur_last_reg;
        chain_next    = main_done ? chain_src : chain_reg;
        take          = 1'b0;
        req.start     = 1'b0;
        req.key       = k1_reg;
        req.blk       = chain_src ^ item.blk
                        ^ (item.last ? (item.pad ? k3_reg : k2_reg) : 128'd0);
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid && !ready_reg) begin
                    req.start  = 1'b1;
                    req.key    = {key_high_reg, key_low_reg};
                    req.blk    = {axm_pkg::FILL_K1, axm_pkg::FILL_K1};
                    phase_next = PH_K1;
                    state_next = S_DERIVE;
                end
                else if (item_valid && room) begin
                    req.start     = 1'b1;
                    take          = 1'b1;
                    cur_last_next = item.last;
                    state_next    = S_MAIN;
                end
            end
            S_DERIVE:
            begin
                if (rsp.done) begin
                    req.key = {key_high_reg, key_low_reg};
                    if (phase_reg == PH_K3) begin
                        ready_next = 1'b1;
                        state_next = S_IDLE;
                    end
                    else begin
                        req.start  = 1'b1;
                        req.blk    = (phase_reg == PH_K1)
                                     ? {axm_pkg::FILL_K2, axm_pkg::FILL_K2}
                                     : {axm_pkg::FILL_K3, axm_pkg::FILL_K3};
                        phase_next = phase_reg + 2'd1;
                    end
                end
            end
            S_MAIN:
            begin
                if (rsp.done) begin
                    if (item_valid && ready_reg && room) begin
                        req.start     = 1'b1;
                        take          = 1'b1;
                        cur_last_next = item.last;
                    end
                    else begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (cfg_write) begin
            ready_next = 1'b0;
        end
    end

    // Derived subkeys
    always_ff @(posedge clk)
    begin
        if (state_reg == S_DERIVE && rsp.done) begin
            unique case (phase_reg)
                PH_K1:   k1_reg <= rsp.result;
                PH_K2:   k2_reg <= rsp.result;
                PH_K3:   k3_reg <= rsp.result;
                default: k1_reg <= k1_reg;
            endcase
        end
    end

    // Control and key registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg    <= S_IDLE;
            phase_reg    <= PH_K1;
            ready_reg    <= 1'b0;
            chain_reg    <= 128'd0;
            cur_last_reg <= 1'b0;
            key_high_reg <= 64'd0;
            key_low_reg  <= 64'd0;
        end
        else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            ready_reg    <= ready_next;
            chain_reg    <= chain_next;
            cur_last_reg <= cur_last_next;
            if (cfg_write && !cfg_index) begin
                key_high_reg <= cfg_data;
            end
            if (cfg_write && cfg_index) begin
                key_low_reg <= cfg_data;
            end
        end
    end

    // Tag queue
    assign empty    = (out_cnt_reg == 2'd0);
    assign do_pop   = pop && !empty;
    assign mac_high = q_reg[rd_ptr_reg][127:64];
    assign mac_low  = q_reg[rd_ptr_reg][63:0];

    always_ff @(posedge clk)
    begin
        if (push) begin
            q_reg[wr_ptr_reg] <= rsp.result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg  <= 1'b0;
            rd_ptr_reg  <= 1'b0;
            out_cnt_reg <= 2'd0;
        end
        else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            out_cnt_reg <= out_cnt_reg + 2'(push) - 2'(do_pop);
        end
    end

    `AXM_ASSERT_IMPLIES(a_start_idle, req.start, !rsp.busy, "AES unit restarted while busy")
    `AXM_ASSERT_IMPLIES(a_push_room, push, out_cnt_reg != 2'd2 || do_pop, "tag queue overflow")
    `AXM_ASSERT_IMPLIES(a_take_valid, take, item_valid && ready_reg, "block taken without keys")
    `AXM_ASSERT_NEXT(a_take_main, take, state_reg == S_MAIN && rsp.busy, "block taken, no AES run")

endmodule

FILE: rtl/core/aes_xcbc_mac_core.sv
// AES-XCBC-MAC (RFC 3566) over 16-byte message words. Push message words with the
// final one marked by last; each last word yields one 128-bit tag, whose first 12 bytes
// are the 96-bit ICV. Blocks run one at a time through the iterative AES unit (one round
// per clock); CBC chaining feeds each result into the next block. After a key write the
// next block is preceded by three subkey encryptions.
// Up to two input words and two tags are queued, so both sides may stall freely.
// Write keys only while the core is idle.
module aes_xcbc_mac_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [63:0] block_high,
    input  logic [63:0] block_low,
    input  logic [4:0]  byte_count,
    input  logic        last,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] mac_high,
    output logic [63:0] mac_low
);

    logic              item_valid;
    axm_pkg::item_t    item;
    logic              take;
    axm_pkg::eng_req_t req;
    axm_pkg::eng_rsp_t rsp;

    axm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .block_high (block_high),
        .block_low  (block_low),
        .byte_count (byte_count),
        .last       (last),
        .item_valid (item_valid),
        .item       (item),
        .take       (take)
    );

    axm_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    axm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .req        (req),
        .rsp        (rsp),
        .empty      (empty),
        .pop        (pop),
        .mac_high   (mac_high),
        .mac_low    (mac_low)
    );

endmodule

FILE: dv/tb_top.sv
module tb_top;

    // Register indexes of the key port
    localparam logic REG_KEY_HIGH = 1'b0;
    localparam logic REG_KEY_LOW  = 1'b1;

    localparam int SETTLE_CYCLES = 100;
    localparam int LONG_HOLD     = 400;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic        cfg_index;
    logic [63:0] cfg_data;
    logic        push;
    logic        full;
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic [4:0]  byte_count;
    logic        last;
    logic        empty;
    logic        pop;
    logic [63:0] mac_high;
    logic [63:0] mac_low;

    aes_xcbc_mac_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push       (push),
        .full       (full),
        .block_high (block_high),
        .block_low  (block_low),
        .byte_count (byte_count),
        .last       (last),
        .empty      (empty),
        .pop        (pop),
        .mac_high   (mac_high),
        .mac_low    (mac_low)
    );

    // Predictor state
    logic [7:0]   sbox_lut [256];
    logic [127:0] aes_key;
    logic [127:0] chain;
    logic [127:0] k1;
    logic [127:0] k2;
    logic [127:0] k3;
    logic         subkeys_valid;
    logic [127:0] tag_queue [$];

    int  errors;
    bit  calm;
    bit  hold_request;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("status: fail");
        $finish;
    end

    function automatic logic [7:0] xt(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[0])
                p = p ^ a;
            a = xt(a);
            b = b >> 1;
        end
        return p;
    endfunction

    // S-box built from the field inverse and the affine map
    task automatic build_sbox();
        logic [7:0] inv;
        logic [7:0] s;
        for (int a = 0; a < 256; a++)
        begin
            inv = 8'h00;
            for (int b = 1; b < 256; b++)
                if (gf_mul(a[7:0], b[7:0]) == 8'h01)
                    inv = b[7:0];
            s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
                ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            sbox_lut[a] = s;
        end
    endtask

    function automatic logic [127:0] aes_enc_model(input logic [127:0] key,
                                                   input logic [127:0] pt);
        logic [7:0]   rk [176];
        logic [7:0]   s [16];
        logic [7:0]   t [16];
        logic [7:0]   w [4];
        logic [7:0]   x;
        logic [7:0]   rc;
        logic [7:0]   all;
        logic [7:0]   a0, a1, a2, a3;
        logic [127:0] res;
        for (int i = 0; i < 16; i++)
            rk[i] = key[127 - 8 * i -: 8];
        rc = 8'h01;
        for (int i = 16; i < 176; i += 4)
        begin
            for (int c = 0; c < 4; c++)
                w[c] = rk[i - 4 + c];
            if ((i % 16) == 0)
            begin
                x = w[0];
                w[0] = sbox_lut[w[1]] ^ rc;
                w[1] = sbox_lut[w[2]];
                w[2] = sbox_lut[w[3]];
                w[3] = sbox_lut[x];
                rc = xt(rc);
            end
            for (int c = 0; c < 4; c++)
                rk[i + c] = rk[i - 16 + c] ^ w[c];
        end
        for (int i = 0; i < 16; i++)
            s[i] = pt[127 - 8 * i -: 8] ^ rk[i];
        for (int r = 1; r <= 10; r++)
        begin
            // SubBytes and ShiftRows
            for (int i = 0; i < 16; i++)
                t[i] = sbox_lut[s[(i & 3) + 4 * (((i >> 2) + (i & 3)) & 3)]];
            if (r < 10)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    a0 = t[4*c];
                    a1 = t[4*c+1];
                    a2 = t[4*c+2];
                    a3 = t[4*c+3];
                    all = a0 ^ a1 ^ a2 ^ a3;
                    t[4*c]   = a0 ^ all ^ xt(a0 ^ a1);
                    t[4*c+1] = a1 ^ all ^ xt(a1 ^ a2);
                    t[4*c+2] = a2 ^ all ^ xt(a2 ^ a3);
                    t[4*c+3] = a3 ^ all ^ xt(a3 ^ a0);
                end
            end
            for (int i = 0; i < 16; i++)
                s[i] = t[i] ^ rk[16 * r + i];
        end
        for (int i = 0; i < 16; i++)
            res[127 - 8 * i -: 8] = s[i];
        return res;
    endfunction

    // Expected tag update for one accepted word
    task automatic mac_predict(input logic [63:0] hi, input logic [63:0] lo,
                               input logic [4:0] cnt, input logic lst);
        logic [127:0] blk;
        logic [127:0] keep;
        if (!subkeys_valid)
        begin
            k1 = aes_enc_model(aes_key, {16{8'h01}});
            k2 = aes_enc_model(aes_key, {16{8'h02}});
            k3 = aes_enc_model(aes_key, {16{8'h03}});
            subkeys_valid = 1'b1;
        end
        blk = {hi, lo};
        if (!lst)
        begin
            chain = aes_enc_model(k1, chain ^ blk);
        end
        else
        begin
            if (cnt >= 5'd16)
                chain = chain ^ blk ^ k2;
            else
            begin
                // Pad: 0x80 at the count, zeros after it
                keep = ~({128{1'b1}} >> (8 * cnt));
                blk = (blk & keep) | (128'h80 << (120 - 8 * cnt));
                chain = chain ^ blk ^ k3;
            end
            tag_queue.push_back(aes_enc_model(k1, chain));
            chain = '0;
        end
    endtask

    task automatic report(input string what, input logic [127:0] got,
                          input logic [127:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    // Result side: checks each tag, idles in bursts, long hold on request
    initial
    begin
        int idle;
        logic [127:0] want;
        idle = 0;
        pop = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
            begin
                if (tag_queue.size() == 0)
                    report("unexpected tag", {mac_high, mac_low}, '0);
                else
                begin
                    want = tag_queue.pop_front();
                    if (mac_high !== want[127:64])
                        report("mac_high", {64'h0, mac_high}, {64'h0, want[127:64]});
                    if (mac_low !== want[63:0])
                        report("mac_low", {64'h0, mac_low}, {64'h0, want[63:0]});
                end
            end
            if (hold_request)
            begin
                hold_request = 1'b0;
                idle = LONG_HOLD;
            end
            if (idle == 0 && !calm && $urandom_range(0, 5) == 0)
                idle = $urandom_range(1, 16);
            if (idle > 0)
            begin
                pop <= 1'b0;
                idle--;
            end
            else
                pop <= 1'b1;
        end
    end

    // Offer one word and wait for it to be taken
    task automatic send_word(input logic [63:0] hi, input logic [63:0] lo,
                             input logic [4:0] cnt, input logic lst);
        push <= 1'b1;
        block_high <= hi;
        block_low <= lo;
        byte_count <= cnt;
        last <= lst;
        do
            @(posedge clk);
        while (full);
        mac_predict(hi, lo, cnt, lst);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    // Drain all tags, then let any trailing words finish
    task automatic settle();
        push <= 1'b0;
        while (tag_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_key(input logic idx, input logic [63:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_KEY_HIGH)
            aes_key[127:64] = val;
        else
            aes_key[63:0] = val;
        subkeys_valid = 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Directed words under the reset key
    task automatic test_directed();
        send_word('0, '0, 5'd0, 1'b1);
        send_word('1, '1, 5'd16, 1'b1);
        send_word('1, '1, 5'd0, 1'b0);
        send_word(rand64(), rand64(), 5'd1, 1'b1);
        send_word('1, '1, 5'd15, 1'b1);
        send_word(rand64(), rand64(), 5'd31, 1'b1);
        send_word(rand64(), rand64(), 5'd17, 1'b1);
        send_word(rand64(), rand64(), 5'd31, 1'b0);
        send_word(rand64(), rand64(), 5'd8, 1'b1);
        send_word('0, '0, 5'd16, 1'b0);
        send_word('0, '0, 5'd16, 1'b0);
        send_word(rand64(), rand64(), 5'd7, 1'b1);
        settle();
    endtask

    // Extreme keys and a key change in the middle of a message
    task automatic test_keys();
        write_key(REG_KEY_HIGH, '1);
        write_key(REG_KEY_LOW, '1);
        send_word('0, '0, 5'd0, 1'b1);
        send_word('1, '1, 5'd16, 1'b0);
        send_word('1, '1, 5'd12, 1'b1);
        settle();
        write_key(REG_KEY_HIGH, '0);
        send_word(rand64(), rand64(), 5'd16, 1'b0);
        settle();
        write_key(REG_KEY_LOW, rand64());
        send_word(rand64(), rand64(), 5'd3, 1'b1);
        settle();
    endtask

    // Receiver holds off while words keep coming
    task automatic test_backpressure();
        hold_request = 1'b1;
        for (int i = 0; i < 10; i++)
            send_word(rand64(), rand64(), 5'($urandom_range(0, 16)), 1'b1);
        settle();
    endtask

    // Random messages of one to six words over several keys
    task automatic test_random();
        int words;
        int len;
        logic [4:0] cnt;
        words = 0;
        for (int phase = 0; phase < 6; phase++)
        begin
            if (phase == 5)
                calm = 1'b1;
            write_key(REG_KEY_HIGH, rand64());
            if ($urandom_range(0, 2) != 0)
                write_key(REG_KEY_LOW, rand64());
            while (words < 120 * (phase + 1))
            begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                begin
                    if (i == len - 1)
                    begin
                        cnt = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(17, 31))
                              : 5'($urandom_range(0, 16));
                        send_word(rand64(), rand64(), cnt, 1'b1);
                    end
                    else
                        send_word(rand64(), rand64(), 5'($urandom_range(0, 31)), 1'b0);
                    words++;
                end
            end
            settle();
        end
    endtask

    initial
    begin
        errors = 0;
        calm = 1'b0;
        hold_request = 1'b0;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_KEY_HIGH;
        cfg_data = '0;
        push = 1'b0;
        block_high = '0;
        block_low = '0;
        byte_count = '0;
        last = 1'b0;
        aes_key = '0;
        chain = '0;
        k1 = '0;
        k2 = '0;
        k3 = '0;
        subkeys_valid = 1'b0;
        build_sbox();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_keys();
        test_backpressure();
        test_random();
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
